[src/tmc_pkg.sv]
// shared types, codes and constants of the thermostat mode controller
package tmc_pkg;

    // heater pulse frame
    localparam int PULSE_SLOTS = 20;
    localparam int SLOT_W      = (PULSE_SLOTS > 2) ? $clog2(PULSE_SLOTS) : 1;

    // button limits
    localparam int LEVEL_W   = 5;
    localparam int LEVEL_MAX = 20;
    localparam int HYST_MAX  = 3;

    // field widths
    localparam int ROOM_W  = 13;
    localparam int TEMP_W  = 10;
    localparam int PCT_W   = 7;
    localparam int KIND_W  = 3;
    localparam int IN_W    = 40;
    localparam int RES_W   = 24;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // register reset values
    localparam logic [TEMP_W-1:0] SUMMER_RST = TEMP_W'(600);
    localparam logic [TEMP_W-1:0] WINTER_RST = TEMP_W'(400);
    localparam logic [PCT_W-1:0]  MIN_RST    = PCT_W'(25);
    localparam logic [PCT_W-1:0]  PCT_MAX    = PCT_W'(100);

    // register indexes
    localparam logic [1:0] REG_SUMMER = 2'd0;
    localparam logic [1:0] REG_WINTER = 2'd1;
    localparam logic [1:0] REG_MIN    = 2'd2;

    // cycle position before the first mode press
    localparam logic [2:0] CYC_IDLE = 3'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_SAMPLE = 3'd1,
        KIND_MODE   = 3'd2,
        KIND_UP     = 3'd3,
        KIND_DOWN   = 3'd4,
        KIND_OFF    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_COOL = 2'd1,
        MODE_HEAT = 2'd2,
        MODE_AUTO = 2'd3
    } t_mode;

    // one result item, mode in the lowest bits
    typedef struct packed {
        logic [1:0]       hysteresis;
        logic             heater_on;
        logic             cooler_on;
        logic [PCT_W-1:0] heat_percent;
        logic [PCT_W-1:0] cool_percent;
        logic [1:0]       mode;
    } t_result;

    localparam int RES_PAD = RES_W - $bits(t_result);

endpackage

[src/thermostat_mode_controller.sv]
// top level of the thermostat mode controller: state update, registers and result stream
//
// Each input item (kind in s_axis_tuser) is applied to the controller state in the
// cycle it is accepted and gives one result item holding the state after it: mode,
// cool and heat percent, cooler and heater enables and hysteresis. The next-state logic
// is combinational and writes a two-entry result buffer, so one item is accepted every
// cycle; s_axis_tready drops only while both buffer entries wait on the output.
// Registers are written through the APB port, and the user must write them only while
// the block is idle; the block itself does not enforce this. The summer threshold is at
// 0x0, the winter threshold at 0x4 and the minimum auto drive percent at 0x8.
module thermostat_mode_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // apb register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tmc_pkg::APB_AW-1:0] paddr,
    input  logic [tmc_pkg::APB_DW-1:0] pwdata,
    output logic [tmc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    // input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // room_temp[12:0], outside_temp[22:13], set_point[32:23], zeros above
    input  logic [tmc_pkg::IN_W-1:0]   s_axis_tdata,
    // kind[2:0]
    input  logic [tmc_pkg::KIND_W-1:0] s_axis_tuser,
    // result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // mode[1:0], cool_percent[8:2], heat_percent[15:9], cooler_on[16],
    // heater_on[17], hysteresis[19:18], zeros above
    output logic [tmc_pkg::RES_W-1:0]  m_axis_tdata
);

    localparam int CMP_W = (tmc_pkg::SLOT_W > tmc_pkg::LEVEL_W) ?
                           tmc_pkg::SLOT_W : tmc_pkg::LEVEL_W;

    // configuration registers
    logic [tmc_pkg::TEMP_W-1:0]  r_summer;
    logic [tmc_pkg::TEMP_W-1:0]  r_winter;
    logic [tmc_pkg::PCT_W-1:0]   r_min_drive;

    // controller state
    tmc_pkg::t_mode              r_mode,       n_mode;
    logic [2:0]                  r_cyc_pos,    n_cyc_pos;
    logic [1:0]                  r_hyst,       n_hyst;
    logic [tmc_pkg::LEVEL_W-1:0] r_heat_level, n_heat_level;
    logic [tmc_pkg::LEVEL_W-1:0] r_cool_level, n_cool_level;
    logic [tmc_pkg::SLOT_W-1:0]  r_slot,       n_slot;
    logic [tmc_pkg::PCT_W-1:0]   r_cool_duty,  n_cool_duty;
    logic [tmc_pkg::PCT_W-1:0]   r_heat_duty,  n_heat_duty;
    logic                        r_cooler,     n_cooler;
    logic                        r_heater,     n_heater;

    logic                        w_accept;
    logic                        w_wr;
    tmc_pkg::t_kind              w_kind;
    logic [tmc_pkg::ROOM_W-1:0]  w_room;
    logic [tmc_pkg::TEMP_W-1:0]  w_outside;
    logic [tmc_pkg::TEMP_W-1:0]  w_setp;
    logic [tmc_pkg::ROOM_W-1:0]  w_setp_ext;
    logic [tmc_pkg::ROOM_W-1:0]  w_cool_err;
    logic [tmc_pkg::ROOM_W-1:0]  w_heat_err;
    logic [tmc_pkg::ROOM_W:0]    w_room_hyst;
    logic [4:0]                  w_hyst_x10;
    logic [tmc_pkg::SLOT_W-1:0]  w_slot_inc;
    logic [2:0]                  w_pos_inc;
    tmc_pkg::t_result            w_result;
    tmc_pkg::t_result            w_out;

    // drive clamp: raise to the minimum, then limit to full scale
    function automatic logic [tmc_pkg::PCT_W-1:0] clamp_drive(
        input logic [tmc_pkg::ROOM_W-1:0] err,
        input logic [tmc_pkg::PCT_W-1:0]  min_pct
    );
        logic [tmc_pkg::ROOM_W-1:0] d;
        d = (err < tmc_pkg::ROOM_W'(min_pct)) ? tmc_pkg::ROOM_W'(min_pct) : err;
        if (d > tmc_pkg::ROOM_W'(tmc_pkg::PCT_MAX)) begin
            d = tmc_pkg::ROOM_W'(tmc_pkg::PCT_MAX);
        end
        return d[tmc_pkg::PCT_W-1:0];
    endfunction

    // level to percent, times five
    function automatic logic [tmc_pkg::PCT_W-1:0] level_pct(
        input logic [tmc_pkg::LEVEL_W-1:0] lvl
    );
        return {lvl, 2'b00} + tmc_pkg::PCT_W'(lvl);
    endfunction

    // apb access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            tmc_pkg::REG_SUMMER: prdata = tmc_pkg::APB_DW'(r_summer);
            tmc_pkg::REG_WINTER: prdata = tmc_pkg::APB_DW'(r_winter);
            tmc_pkg::REG_MIN:    prdata = tmc_pkg::APB_DW'(r_min_drive);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summer    <= tmc_pkg::SUMMER_RST;
            r_winter    <= tmc_pkg::WINTER_RST;
            r_min_drive <= tmc_pkg::MIN_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                tmc_pkg::REG_SUMMER: r_summer    <= pwdata[tmc_pkg::TEMP_W-1:0];
                tmc_pkg::REG_WINTER: r_winter    <= pwdata[tmc_pkg::TEMP_W-1:0];
                tmc_pkg::REG_MIN:    r_min_drive <= pwdata[tmc_pkg::PCT_W-1:0];
                default:             ;
            endcase
        end
    end

    // input fields
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_kind     = tmc_pkg::t_kind'(s_axis_tuser);
    assign w_room     = s_axis_tdata[12:0];
    assign w_outside  = s_axis_tdata[22:13];
    assign w_setp     = s_axis_tdata[32:23];
    assign w_setp_ext = tmc_pkg::ROOM_W'(w_setp);

    // sample arithmetic
    assign w_cool_err  = w_room - w_setp_ext;
    assign w_heat_err  = w_setp_ext - w_room;
    assign w_hyst_x10  = {r_hyst, 3'b000} + {2'b00, r_hyst, 1'b0};
    assign w_room_hyst = {1'b0, w_room} + (tmc_pkg::ROOM_W + 1)'(w_hyst_x10);

    assign w_slot_inc = (r_slot == tmc_pkg::SLOT_W'(tmc_pkg::PULSE_SLOTS - 1)) ?
                        '0 : r_slot + 1'b1;
    assign w_pos_inc  = r_cyc_pos + 3'd1;

    // next state for one item
    always_comb begin
        n_mode       = r_mode;
        n_cyc_pos    = r_cyc_pos;
        n_hyst       = r_hyst;
        n_heat_level = r_heat_level;
        n_cool_level = r_cool_level;
        n_slot       = r_slot;
        n_cool_duty  = r_cool_duty;
        n_heat_duty  = r_heat_duty;
        n_cooler     = r_cooler;
        n_heater     = r_heater;

        case (w_kind)
            tmc_pkg::KIND_TICK: begin
                if (r_mode == tmc_pkg::MODE_HEAT) begin
                    n_slot   = w_slot_inc;
                    n_heater = CMP_W'(w_slot_inc) < CMP_W'(r_heat_level);
                end
            end
            tmc_pkg::KIND_SAMPLE: begin
                if (r_mode == tmc_pkg::MODE_AUTO) begin
                    if (w_outside > r_summer) begin
                        n_heat_duty = '0;
                        n_heater    = 1'b0;
                        if (w_room > w_setp_ext) begin
                            n_cool_duty = clamp_drive(w_cool_err, r_min_drive);
                        end else if (w_room_hyst <= (tmc_pkg::ROOM_W + 1)'(w_setp)) begin
                            n_cool_duty = '0;
                        end
                        n_cooler = n_cool_duty != '0;
                    end else if (w_outside < r_winter) begin
                        n_cool_duty = '0;
                        n_cooler    = 1'b0;
                        if (w_setp_ext > w_room) begin
                            n_heat_duty = clamp_drive(w_heat_err, r_min_drive);
                            n_heater    = 1'b1;
                        end else begin
                            n_heat_duty = '0;
                            n_heater    = 1'b0;
                        end
                    end else begin
                        n_cool_duty = '0;
                        n_heat_duty = '0;
                        n_cooler    = 1'b0;
                        n_heater    = 1'b0;
                    end
                end
            end
            tmc_pkg::KIND_MODE: begin
                if (r_cyc_pos >= tmc_pkg::CYC_IDLE) begin
                    n_cyc_pos = 3'd0;
                    n_mode    = tmc_pkg::MODE_OFF;
                end else if (w_pos_inc == 3'd1) begin
                    n_cyc_pos = w_pos_inc;
                    n_mode    = tmc_pkg::MODE_COOL;
                end else if (w_pos_inc == 3'd2) begin
                    n_cyc_pos = w_pos_inc;
                    n_mode    = tmc_pkg::MODE_HEAT;
                end else begin
                    n_cyc_pos = 3'd0;
                    n_mode    = tmc_pkg::MODE_AUTO;
                end
            end
            tmc_pkg::KIND_UP: begin
                case (r_mode)
                    tmc_pkg::MODE_AUTO: begin
                        if (r_hyst < 2'(tmc_pkg::HYST_MAX)) n_hyst = r_hyst + 2'd1;
                    end
                    tmc_pkg::MODE_HEAT: begin
                        if (r_heat_level < tmc_pkg::LEVEL_W'(tmc_pkg::LEVEL_MAX)) begin
                            n_heat_level = r_heat_level + 1'b1;
                        end
                    end
                    tmc_pkg::MODE_COOL: begin
                        if (r_cool_level < tmc_pkg::LEVEL_W'(tmc_pkg::LEVEL_MAX)) begin
                            n_cool_level = r_cool_level + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            tmc_pkg::KIND_DOWN: begin
                case (r_mode)
                    tmc_pkg::MODE_AUTO: begin
                        if (r_hyst != '0) n_hyst = r_hyst - 2'd1;
                    end
                    tmc_pkg::MODE_HEAT: begin
                        if (r_heat_level != '0) n_heat_level = r_heat_level - 1'b1;
                    end
                    tmc_pkg::MODE_COOL: begin
                        if (r_cool_level != '0) n_cool_level = r_cool_level - 1'b1;
                    end
                    default: ;
                endcase
            end
            tmc_pkg::KIND_OFF: begin
                n_mode    = tmc_pkg::MODE_OFF;
                n_cyc_pos = tmc_pkg::CYC_IDLE;
            end
            default: ;
        endcase

        // outputs that follow the mode reached
        case (n_mode)
            tmc_pkg::MODE_OFF: begin
                n_cool_duty = '0;
                n_heat_duty = '0;
                n_cooler    = 1'b0;
                n_heater    = 1'b0;
            end
            tmc_pkg::MODE_COOL: begin
                n_cool_duty = level_pct(n_cool_level);
                n_cooler    = n_cool_level != '0;
                n_heat_duty = '0;
                n_heater    = 1'b0;
            end
            tmc_pkg::MODE_HEAT: begin
                if (r_mode != tmc_pkg::MODE_HEAT) n_heater = 1'b0;
                n_heat_duty = level_pct(n_heat_level);
                n_cool_duty = '0;
                n_cooler    = 1'b0;
            end
            default: begin
                if (r_mode != tmc_pkg::MODE_AUTO) begin
                    n_cool_duty = '0;
                    n_heat_duty = '0;
                    n_cooler    = 1'b0;
                    n_heater    = 1'b0;
                end
            end
        endcase
    end

    // state registers, updated per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= tmc_pkg::MODE_OFF;
            r_cyc_pos    <= tmc_pkg::CYC_IDLE;
            r_hyst       <= '0;
            r_heat_level <= '0;
            r_cool_level <= '0;
            r_slot       <= '0;
            r_cool_duty  <= '0;
            r_heat_duty  <= '0;
            r_cooler     <= 1'b0;
            r_heater     <= 1'b0;
        end else if (w_accept) begin
            r_mode       <= n_mode;
            r_cyc_pos    <= n_cyc_pos;
            r_hyst       <= n_hyst;
            r_heat_level <= n_heat_level;
            r_cool_level <= n_cool_level;
            r_slot       <= n_slot;
            r_cool_duty  <= n_cool_duty;
            r_heat_duty  <= n_heat_duty;
            r_cooler     <= n_cooler;
            r_heater     <= n_heater;
        end
    end

    // result item from the state after the item
    always_comb begin
        w_result.mode         = n_mode;
        w_result.cool_percent = n_cool_duty;
        w_result.heat_percent = n_heat_duty;
        w_result.cooler_on    = n_cooler;
        w_result.heater_on    = n_heater;
        w_result.hysteresis   = n_hyst;
    end

    tmc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = {{tmc_pkg::RES_PAD{1'b0}}, w_out};

    // off mode keeps every drive at rest
    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == tmc_pkg::MODE_OFF |->
            r_cool_duty == '0 && r_heat_duty == '0 && !r_cooler && !r_heater)
        else $error("drive active in off mode");

    // the button cycle position tracks the mode
    a_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cyc_pos == tmc_pkg::CYC_IDLE |-> r_mode == tmc_pkg::MODE_OFF) and
        (r_mode == tmc_pkg::MODE_AUTO |-> r_cyc_pos == 3'd0))
        else $error("cycle position out of step with mode");

    // levels and pulse slot stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heat_level <= tmc_pkg::LEVEL_W'(tmc_pkg::LEVEL_MAX) &&
        r_cool_level <= tmc_pkg::LEVEL_W'(tmc_pkg::LEVEL_MAX) &&
        r_slot <= tmc_pkg::SLOT_W'(tmc_pkg::PULSE_SLOTS - 1))
        else $error("level or pulse slot out of range");

    // the cooler enable follows a nonzero cool drive
    a_cooler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cooler == (r_cool_duty != '0))
        else $error("cooler enable disagrees with cool drive");

endmodule

[src/tmc_out_buf.sv]
// two-entry result buffer that decouples the state logic from the output stream
module tmc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tmc_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_out_ready,
    output tmc_pkg::t_result o_data
);

    tmc_pkg::t_result r_data0;
    tmc_pkg::t_result r_data1;
    logic             r_valid0;
    logic             r_valid1;
    logic             w_pop;

    assign o_ready = !r_valid1;
    assign o_valid = r_valid0;
    assign o_data  = r_data0;
    assign w_pop   = r_valid0 && i_out_ready;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else if (w_pop) begin
            r_valid0 <= r_valid1 || i_push;
            r_valid1 <= r_valid1 && i_push;
        end else if (i_push) begin
            r_valid0 <= 1'b1;
            r_valid1 <= r_valid0;
        end
    end

    // payload, head first
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_data0 <= r_valid1 ? r_data1 : i_data;
            if (r_valid1 && i_push) begin
                r_data1 <= i_data;
            end
        end else if (i_push) begin
            if (!r_valid0) begin
                r_data0 <= i_data;
            end else begin
                r_data1 <= i_data;
            end
        end
    end

    // second entry is only filled behind the head
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid1 |-> r_valid0)
        else $error("second entry valid without head");

    // a waiting head is never dropped
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid0 && !i_out_ready |=> r_valid0 && $stable(r_data0))
        else $error("stalled head lost");

    // a push into a full buffer cannot happen
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid1 && !w_pop |=> r_valid1 && $stable(r_data1))
        else $error("second entry overwritten");

endmodule

[tb/sv/testbench.sv]
// self-checking stream testbench for the thermostat mode controller with its own state predictor
module testbench;
    import tmc_pkg::*;

    // spare kind codes that must leave the state alone
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam int PCT_PER_LEVEL = 5;
    localparam int TEMP_TOP      = (1 << TEMP_W) - 1;
    localparam int ROOM_TOP      = (1 << ROOM_W) - 1;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [APB_DW-1:0]   pwdata        = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // room_temp[12:0], outside_temp[22:13], set_point[32:23], zeros above
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    // kind[2:0]
    logic [KIND_W-1:0]   s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // mode[1:0], cool_percent[8:2], heat_percent[15:9], cooler_on[16],
    // heater_on[17], hysteresis[19:18], zeros above
    logic [RES_W-1:0]    m_axis_tdata;

    thermostat_mode_controller u_top (
        .i_clk,
        .i_rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    // predicted controller state, reset values
    t_mode              mode_now   = MODE_OFF;
    logic [2:0]         cyc_pos    = CYC_IDLE;
    logic [1:0]         hyst       = '0;
    logic [LEVEL_W-1:0] heat_lvl   = '0;
    logic [LEVEL_W-1:0] cool_lvl   = '0;
    logic [SLOT_W-1:0]  slot_pos   = '0;
    logic [PCT_W-1:0]   cool_duty  = '0;
    logic [PCT_W-1:0]   heat_duty  = '0;
    logic               cooler_en  = 1'b0;
    logic               heater_en  = 1'b0;

    // predicted register contents
    logic [TEMP_W-1:0]  summer     = SUMMER_RST;
    logic [TEMP_W-1:0]  winter     = WINTER_RST;
    logic [PCT_W-1:0]   min_drive  = MIN_RST;

    t_result pending_outputs[$];

    int  items_sent      = 0;
    int  effective_items = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  settings_run    = 0;
    int  idle_pct        = 0;
    int  stall_pct       = 0;
    int  stall_left      = 0;
    bit  no_idling       = 1'b0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // auto drive: raise to the minimum, then cap at full
    function automatic logic [PCT_W-1:0] clamp_drive(input int err);
        int d;
        d = err;
        if (d < int'(min_drive)) d = int'(min_drive);
        if (d > 100) d = 100;
        return PCT_W'(d);
    endfunction

    // apply one item to the predicted state and return the outputs after it
    function automatic t_result thermostat_after_item(input logic [KIND_W-1:0] kind,
                                                      input int room, input int outside,
                                                      input int setp);
        t_mode   prev;
        t_result r;
        bit      up;
        prev = mode_now;
        up   = (kind == KIND_UP);
        case (kind)
            KIND_TICK: begin
                if (mode_now == MODE_HEAT) begin
                    if (int'(slot_pos) + 1 >= PULSE_SLOTS) slot_pos = '0;
                    else slot_pos = slot_pos + 1'b1;
                    heater_en = (slot_pos < heat_lvl);
                end
            end
            KIND_SAMPLE: begin
                if (mode_now == MODE_AUTO) begin
                    if (outside > int'(summer)) begin
                        heat_duty = '0;
                        heater_en = 1'b0;
                        if (room - setp > 0) cool_duty = clamp_drive(room - setp);
                        else if (room <= setp - int'(hyst) * 10) cool_duty = '0;
                        cooler_en = (cool_duty != 0);
                    end else if (outside < int'(winter)) begin
                        cool_duty = '0;
                        cooler_en = 1'b0;
                        if (setp - room > 0) begin
                            heat_duty = clamp_drive(setp - room);
                            heater_en = 1'b1;
                        end else begin
                            heat_duty = '0;
                            heater_en = 1'b0;
                        end
                    end else begin
                        {cool_duty, heat_duty, cooler_en, heater_en} = '0;
                    end
                end
            end
            KIND_MODE: begin
                if (cyc_pos >= CYC_IDLE) begin
                    cyc_pos  = '0;
                    mode_now = MODE_OFF;
                end else begin
                    // position number matches the mode code for cool and heat
                    cyc_pos = cyc_pos + 1'b1;
                    if (cyc_pos < 3'(MODE_AUTO)) begin
                        mode_now = t_mode'(cyc_pos[1:0]);
                    end else begin
                        mode_now = MODE_AUTO;
                        cyc_pos  = '0;
                    end
                end
            end
            KIND_UP, KIND_DOWN: begin
                case (mode_now)
                    MODE_AUTO: begin
                        if (up && hyst < HYST_MAX) hyst = hyst + 1'b1;
                        else if (!up && hyst > 0) hyst = hyst - 1'b1;
                    end
                    MODE_HEAT: begin
                        if (up && heat_lvl < LEVEL_MAX) heat_lvl = heat_lvl + 1'b1;
                        else if (!up && heat_lvl > 0) heat_lvl = heat_lvl - 1'b1;
                    end
                    MODE_COOL: begin
                        if (up && cool_lvl < LEVEL_MAX) cool_lvl = cool_lvl + 1'b1;
                        else if (!up && cool_lvl > 0) cool_lvl = cool_lvl - 1'b1;
                    end
                    default: ;
                endcase
            end
            KIND_OFF: begin
                mode_now = MODE_OFF;
                cyc_pos  = CYC_IDLE;
            end
            default: ;
        endcase

        // outputs follow the mode
        case (mode_now)
            MODE_OFF: {cool_duty, heat_duty, cooler_en, heater_en} = '0;
            MODE_COOL: begin
                cool_duty = PCT_W'(int'(cool_lvl) * PCT_PER_LEVEL);
                cooler_en = (cool_lvl != 0);
                heat_duty = '0;
                heater_en = 1'b0;
            end
            MODE_HEAT: begin
                if (prev != MODE_HEAT) heater_en = 1'b0;
                heat_duty = PCT_W'(int'(heat_lvl) * PCT_PER_LEVEL);
                cool_duty = '0;
                cooler_en = 1'b0;
            end
            default: begin
                if (prev != MODE_AUTO) {cool_duty, heat_duty, cooler_en, heater_en} = '0;
            end
        endcase

        r.mode         = mode_now;
        r.cool_percent = cool_duty;
        r.heat_percent = heat_duty;
        r.cooler_on    = cooler_en;
        r.heater_on    = heater_en;
        r.hysteresis   = hyst;
        return r;
    endfunction

    // send one item and record the outputs it should produce
    task automatic send_item(input logic [KIND_W-1:0] kind, input int room,
                             input int outside, input int setp);
        if (!no_idling && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_W - ROOM_W - 2 * TEMP_W){1'b0}}, TEMP_W'(setp),
                          TEMP_W'(outside), ROOM_W'(room)};
        do @(posedge i_clk); while (!s_axis_tready);
        // items the block ignores in the current mode are not counted
        if (!(kind > KIND_OFF
              || (kind == KIND_TICK && mode_now != MODE_HEAT)
              || (kind == KIND_SAMPLE && mode_now != MODE_AUTO)
              || ((kind == KIND_UP || kind == KIND_DOWN) && mode_now == MODE_OFF)))
            effective_items++;
        items_sent++;
        pending_outputs.push_back(thermostat_after_item(kind, room, outside, setp));
        @(negedge i_clk);
    endtask

    // item whose data fields are random over their full width
    task automatic send_kind(input logic [KIND_W-1:0] kind);
        send_item(kind, $urandom_range(0, ROOM_TOP), $urandom_range(0, TEMP_TOP),
                  $urandom_range(0, TEMP_TOP));
    endtask

    // wait until every predicted result has come out and the block is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    // register write followed by a read back
    task automatic reg_write(input logic [1:0] idx, input int value);
        logic [APB_DW-1:0] stored;
        stored  = (idx == REG_MIN) ? APB_DW'(value & 'h7F) : APB_DW'(value & 'h3FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SUMMER: summer    = TEMP_W'(stored);
            REG_WINTER: winter    = TEMP_W'(stored);
            default:    min_drive = PCT_W'(stored);
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register 0x%h read back %h, expected %h", paddr, prdata, stored);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // walk the mode button to the wanted mode, sometimes from off
    task automatic enter_mode(input t_mode target);
        if ($urandom_range(1) == 1) send_kind(KIND_OFF);
        while (mode_now != target) send_kind(KIND_MODE);
    endtask

    // manual cool level changes with a random up/down bias, with the odd tick or sample
    task automatic cool_run();
        int bias;
        int r;
        enter_mode(MODE_COOL);
        bias = $urandom_range(20, 90);
        repeat ($urandom_range(3, 30)) begin
            r = $urandom_range(99);
            if (r < 3) send_kind(r == 0 ? KIND_TICK : KIND_SAMPLE);
            else send_kind(r < bias ? KIND_UP : KIND_DOWN);
        end
    endtask

    // heat level set up, then a stretch of pulse ticks
    task automatic heat_run();
        int r;
        enter_mode(MODE_HEAT);
        repeat ($urandom_range(0, 22))
            send_kind($urandom_range(5) == 0 ? KIND_DOWN : KIND_UP);
        repeat ($urandom_range(5, 45)) begin
            r = $urandom_range(99);
            if (r < 10) send_kind(r < 5 ? KIND_UP : KIND_DOWN);
            else send_kind(KIND_TICK);
        end
    endtask

    // auto samples around the thresholds and the set point
    task automatic auto_run();
        int setp;
        int outside;
        int room;
        int r;
        enter_mode(MODE_AUTO);
        repeat ($urandom_range(0, 4))
            send_kind($urandom_range(1) == 1 ? KIND_UP : KIND_DOWN);
        setp = $urandom_range(0, 1000);
        repeat ($urandom_range(8, 40)) begin
            r = $urandom_range(99);
            if (r < 6) begin
                send_kind(r < 3 ? KIND_UP : KIND_DOWN);
            end else if (r < 8) begin
                send_kind(r == 6 ? KIND_TICK : KIND_MODE);
            end else begin
                if (r < 14) setp = $urandom_range(0, TEMP_TOP);
                case ($urandom_range(0, 9))
                    0, 1, 2: outside = int'(summer) + int'($urandom_range(0, 4)) - 2;
                    3, 4, 5: outside = int'(winter) + int'($urandom_range(0, 4)) - 2;
                    6, 7:    outside = $urandom_range(0, TEMP_TOP);
                    8:       outside = 0;
                    default: outside = TEMP_TOP;
                endcase
                if (outside < 0) outside = 0;
                if (outside > TEMP_TOP) outside = TEMP_TOP;
                if ($urandom_range(7) == 0) room = $urandom_range(0, ROOM_TOP);
                else room = setp + int'($urandom_range(0, 100)) - 50;
                if (room < 0) room = 0;
                send_item(KIND_SAMPLE, room, outside, setp);
            end
        end
    endtask

    // anything at all, spare kinds included
    task automatic noise_run();
        repeat ($urandom_range(1, 8)) send_kind(KIND_W'($urandom_range(0, 7)));
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // mix of sequences until enough state-changing items have gone in
    task automatic random_mix(input int count);
        int target;
        int r;
        target = effective_items + count;
        while (effective_items < target) begin
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            r = $urandom_range(99);
            if (r < 20) cool_run();
            else if (r < 50) heat_run();
            else if (r < 85) auto_run();
            else noise_run();
        end
    endtask

    // spare kinds, ignored items in off, mode stepping
    task automatic test_buttons_and_modes();
        idle_pct  = 30;
        stall_pct = 30;
        send_item(KIND_SPARE_6, ROOM_TOP, TEMP_TOP, TEMP_TOP);
        send_item(KIND_SPARE_7, 0, 0, 0);
        send_kind(KIND_TICK);
        send_kind(KIND_UP);
        send_kind(KIND_MODE);
    endtask

    // manual levels and the heater pulse
    task automatic test_manual_levels();
        send_kind(KIND_MODE);
        send_kind(KIND_UP);
        send_kind(KIND_UP);
        send_kind(KIND_DOWN);
        send_kind(KIND_MODE);
        send_kind(KIND_UP);
        send_kind(KIND_UP);
        send_kind(KIND_TICK);
        send_kind(KIND_TICK);
    endtask

    // auto cooling, hold band, heating, idle and the threshold edges
    task automatic test_auto_decisions();
        send_kind(KIND_MODE);
        repeat (3) send_kind(KIND_UP);
        send_item(KIND_SAMPLE, 5000, 1000, 0);
        send_item(KIND_SAMPLE, 495, 601, 500);
        send_item(KIND_SAMPLE, 470, 601, 500);
        send_item(KIND_SAMPLE, 0, 0, 1000);
        send_item(KIND_SAMPLE, 300, 399, 300);
        send_item(KIND_SAMPLE, 0, 600, 1000);
        send_item(KIND_SAMPLE, 0, 400, 1000);
        send_kind(KIND_OFF);
    endtask

    // random traffic under several register settings, extremes included
    task automatic test_register_settings();
        int phase;
        int s_val;
        int w_val;
        int m_val;
        for (phase = 0; phase < 7; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: begin s_val = 0;    w_val = TEMP_TOP; m_val = 0;   end
                    2: begin s_val = TEMP_TOP; w_val = 0;    m_val = 100; end
                    3: begin s_val = 500;  w_val = 500;      m_val = 127; end
                    4: begin s_val = 1000; w_val = 1000;     m_val = 1;   end
                    5: begin
                        s_val = $urandom_range(0, TEMP_TOP);
                        w_val = $urandom_range(0, TEMP_TOP);
                        m_val = $urandom_range(0, 127);
                    end
                    default: begin s_val = 600; w_val = 400; m_val = 25; end
                endcase
                drain_results();
                reg_write(REG_SUMMER, s_val);
                reg_write(REG_WINTER, w_val);
                reg_write(REG_MIN, m_val);
            end
            settings_run++;
            random_mix(150);
        end
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_steady_stream();
        no_idling = 1'b1;
        random_mix(200);
    endtask

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (no_idling) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            results_checked++;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item %h arrived with nothing pending", m_axis_tdata);
            end else begin
                want = pending_outputs.pop_front();
                if (got !== want || m_axis_tdata[RES_W-1:$bits(t_result)] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d expected: mode %0d cool %0d heat %0d",
                                 results_checked, want.mode, want.cool_percent,
                                 want.heat_percent);
                        $display("  cooler %0b heater %0b hyst %0d",
                                 want.cooler_on, want.heater_on, want.hysteresis);
                        $display("  got: mode %0d cool %0d heat %0d",
                                 got.mode, got.cool_percent, got.heat_percent);
                        $display("  cooler %0b heater %0b hyst %0d pad %h",
                                 got.cooler_on, got.heater_on, got.hysteresis,
                                 m_axis_tdata[RES_W-1:$bits(t_result)]);
                    end
                end
            end
        end
    end

    // test sequence
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_buttons_and_modes();
        test_manual_levels();
        test_auto_decisions();
        test_register_settings();
        test_steady_stream();
        drain_results();
        $display("ran %0d items (%0d acting on state) under %0d register settings",
                 items_sent, effective_items, settings_run);
        $display("compared %0d result items, %0d mismatching", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run time limit
    initial begin
        #10_000_000;
        $display("timeout with %0d results still pending", pending_outputs.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
